// ===== rtl/sign_grouped_sorter_top_defines.svh =====
// Assertion macros used by the checker file of the sign-grouped sorter.
// Depends on nothing; included by the file that holds the assertions.
`ifndef SIGN_GROUPED_SORTER_TOP_DEFINES_SVH
`define SIGN_GROUPED_SORTER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SGS_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sgs_pkg.sv =====
// Shared types, constants and the ordering function of the sign-grouped sorter.
// Depends on nothing; used by the cell, the top level and the checker.
package sgs_pkg;

	localparam int MAX_ITEMS_DEF = 32;
	localparam int VAL_W = 32;
	localparam int GRP_W = 2;
	localparam int RANK_W = GRP_W + VAL_W;

	// Group codes: a lower code is emitted first.
	localparam logic [GRP_W-1:0] GRP_NEG = 2'd0;
	localparam logic [GRP_W-1:0] GRP_POS = 2'd1;
	localparam logic [GRP_W-1:0] GRP_ZERO = 2'd2;

	// Control of every cell in the current cycle.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	// Contents that a cell hands to its neighbor.
	typedef struct packed {
		logic valid;
		logic [VAL_W-1:0] value;
	} cell_bus_t;

	// Maps a value to an unsigned rank; a smaller rank leaves the chain first.
	// Negatives use the inverted bits so that values closest to zero come first.
	function automatic logic [RANK_W-1:0] sort_rank(input logic [VAL_W-1:0] v);
		logic [RANK_W-1:0] r;
		if (v[VAL_W-1]) begin
			r = {GRP_NEG, ~v};
		end else if (v != '0) begin
			r = {GRP_POS, v};
		end else begin
			r = {GRP_ZERO, {VAL_W{1'b0}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/sign_grouped_sorter_top.sv =====
// Sign-grouped sorter: a chain of MAX_ITEMS cells kept in emit order while loading.
// The first result is offered in the cycle after the closing item is accepted. It takes
// one item per cycle while loading, then gives one result per cycle while draining
// as long as m_axis_tready is high; the cell chain is busy for the whole drain.
// Reset clears every valid bit and the overflow flag at once.
module sign_grouped_sorter_top #(
	parameter int MAX_ITEMS = sgs_pkg::MAX_ITEMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [sgs_pkg::VAL_W-1:0] s_axis_tdata,  // [31:0] sample_value
	input  logic                      s_axis_tlast,  // last_item
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [sgs_pkg::VAL_W-1:0] m_axis_tdata,  // [31:0] sorted_value
	output logic                      m_axis_tlast,  // last_result
	output logic                      m_axis_tuser   // [0] overflowed
);
	import sgs_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic                ovf_q;
	logic                in_acc;
	logic                out_acc;
	logic                full;
	cell_ctrl_t          ctrl;
	logic [RANK_W-1:0]   key_rank;
	cell_bus_t           bus_v [MAX_ITEMS];
	logic                take_v [MAX_ITEMS];

	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_DRAIN);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign full = bus_v[MAX_ITEMS-1].valid;
	assign ctrl = '{insert: in_acc && !full, shift: out_acc};
	assign key_rank = sort_rank(s_axis_tdata);

	// The head cell is the output register.
	assign m_axis_tdata = bus_v[0].value;
	assign m_axis_tlast = !bus_v[1].valid;
	assign m_axis_tuser = ovf_q;

	// Row of cells; each takes from its left neighbor on insert, right on drain.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		cell_bus_t prev_b;
		cell_bus_t next_b;
		logic      prev_t;
		if (i == 0) begin : g_head
			assign prev_b = '0;
			assign prev_t = 1'b0;
		end else begin : g_body
			assign prev_b = bus_v[i-1];
			assign prev_t = take_v[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_b = '0;
		end else begin : g_inner
			assign next_b = bus_v[i+1];
		end
		sgs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key_value (s_axis_tdata),
			.key_rank  (key_rank),
			.prev_bus  (prev_b),
			.prev_take (prev_t),
			.next_bus  (next_b),
			.bus       (bus_v[i]),
			.take      (take_v[i])
		);
	end

	// Load/drain sequencing and the overflow flag of the current vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ovf_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_acc && m_axis_tlast) begin
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sgs_cell.sv =====
// One cell of the insertion-sort chain: holds one element and its valid bit.
// Depends on sgs_pkg for the bus and control types and the ordering function.
module sgs_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sgs_pkg::cell_ctrl_t          ctrl,
	input  logic [sgs_pkg::VAL_W-1:0]    key_value,
	input  logic [sgs_pkg::RANK_W-1:0]   key_rank,
	input  sgs_pkg::cell_bus_t           prev_bus,
	input  logic                         prev_take,
	input  sgs_pkg::cell_bus_t           next_bus,
	output sgs_pkg::cell_bus_t           bus,
	output logic                         take
);
	import sgs_pkg::*;

	logic             valid_q;
	logic [VAL_W-1:0] value_q;

	// The new element belongs at or before this cell.
	assign take = !valid_q || (key_rank < sort_rank(value_q));
	assign bus = '{valid: valid_q, value: value_q};

	// Valid bit: shift toward the head on drain, make room on insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_bus.valid;
		end else if (ctrl.insert) begin
			if (prev_take) begin
				valid_q <= prev_bus.valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Element register follows the same moves without a reset.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_bus.value;
		end else if (ctrl.insert) begin
			if (prev_take) begin
				value_q <= prev_bus.value;
			end else if (take) begin
				value_q <= key_value;
			end
		end
	end

endmodule

// ===== rtl/sgs_checker.sv =====
// Port-level checker for the sign-grouped sorter and its bind to the top level.
// Depends on sgs_pkg and the assertion macros in sign_grouped_sorter_top_defines.svh.
`include "sign_grouped_sorter_top_defines.svh"

module sgs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      s_axis_tlast,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [sgs_pkg::VAL_W-1:0] m_axis_tdata,
	input logic                      m_axis_tlast,
	input logic                      m_axis_tuser
);

	logic both_open;
	logic in_close;
	logic out_last;
	logic out_mid;
	logic out_stall;

	// Handshake events that the properties below refer to.
	assign both_open = s_axis_tready && m_axis_tvalid;
	assign in_close = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_last = m_axis_tvalid && m_axis_tready && m_axis_tlast;
	assign out_mid = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// Loading and draining never overlap.
	`SGS_ASSERT_ALWAYS(a_no_overlap, clk, arst_n, !both_open, "load and drain overlap")

	// A closing item starts the drain in the next cycle.
	`SGS_ASSERT_NEXT(a_close_drain, clk, arst_n, in_close, m_axis_tvalid, "no drain")

	// Taking the final result reopens the input.
	`SGS_ASSERT_NEXT(a_last_reopen, clk, arst_n, out_last, s_axis_tready, "input shut")

	// A stalled result holds its value.
	`SGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "moved")

	// The overflow flag is the same on every result of one vector.
	`SGS_ASSERT_NEXT(a_ovf_steady, clk, arst_n, out_mid, $stable(m_axis_tuser), "ovf moved")

endmodule

bind sign_grouped_sorter_top sgs_checker u_sgs_checker (.*);
